// ===== src/npcs_pkg.sv =====
// Package for the nearest palette color search unit.
// Holds the shared types, the FSM states and the query color expansion.
// No dependencies.
package npcs_pkg;

    // Default number of palette entries
    localparam int unsigned PALETTE_ENTRIES_DEF = 256;

    // Field widths
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned COLOR_W = 15;
    localparam int unsigned SQ_W    = 2 * CHAN_W;
    localparam int unsigned DIST_W  = 18;

    // Entry that always reads as black
    localparam logic [INDEX_W-1:0] TRANSPARENT_IDX = 8'd255;

    // Starting distance: above any real distance, so the first entry always wins
    localparam logic [DIST_W-1:0] START_DIST = {DIST_W{1'b1}};

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // Control from the sequencer to the distance unit
    typedef struct packed {
        logic               clear;
        logic               step;
        logic [INDEX_W-1:0] index;
    } t_dist_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } t_state;

    // Expand a 5:5:5 color to 8 bits a channel: scale by 8, add 4
    function automatic t_rgb expand_color(input logic [COLOR_W-1:0] c);
        t_rgb q;
        q.red   = {c[4:0],   3'b100};
        q.green = {c[9:5],   3'b100};
        q.blue  = {c[14:10], 3'b100};
        return q;
    endfunction

endpackage

// ===== src/npcs_if.sv =====
// Handshake interfaces for the request and response channels.
// Depends on npcs_pkg for field widths.
interface npcs_in_if
    import npcs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [INDEX_W-1:0] entry_index;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [COLOR_W-1:0] color15;

    modport source (output valid, req_type, entry_index, red, green, blue, color15,
                    input ready);
    modport sink   (input valid, req_type, entry_index, red, green, blue, color15,
                    output ready);
endinterface

interface npcs_out_if
    import npcs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] nearest_index;
    logic [DIST_W-1:0]  min_distance;

    modport source (output valid, nearest_index, min_distance, input ready);
    modport sink   (input valid, nearest_index, min_distance, output ready);
endinterface

// ===== src/nearest_palette_color_search_unit.sv =====
// Top level of the nearest palette color search unit.
// Depends on npcs_pkg, npcs_if, npcs_cell and npcs_dist.
//
// The palette sits in a ring of PALETTE_ENTRIES cells, one entry per cell.
// A load word writes one cell and gives no response; a load to entry 255
// stores black, and a load beyond the palette is dropped. A query word
// rotates the ring once, one entry per cycle past a single two-stage
// distance unit, so a query holds the block through its run, flush and
// done states before the next word is taken; the ring is back in place
// when the query ends. The response waits in an output register, so
// loads and a new query are taken while it is still unclaimed. Ties go
// to the lowest index. The palette has no reset and needs no clearing
// pass: every entry below the palette size must be loaded before the
// first query.
module nearest_palette_color_search_unit
    import npcs_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    npcs_in_if.sink     i_req,
    npcs_out_if.source  o_rsp
);

    localparam int unsigned CNT_W = $clog2(PALETTE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PALETTE_ENTRIES - 1);
    localparam logic [INDEX_W:0] ENTRY_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_rgb   r_query;

    logic w_accept, w_load, w_query, w_load_ok, w_shift, w_out_load;
    t_rgb w_load_data;
    t_rgb w_cell [PALETTE_ENTRIES];
    t_dist_ctl w_ctl;

    logic [INDEX_W-1:0] w_best_index;
    logic [DIST_W-1:0]  w_best_dist;

    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;
    logic [DIST_W-1:0]  r_out_dist;

    assign w_accept  = i_req.valid && i_req.ready;
    assign w_load    = w_accept && (i_req.req_type == REQ_LOAD);
    assign w_query   = w_accept && (i_req.req_type == REQ_QUERY);
    assign w_load_ok = ({1'b0, i_req.entry_index} < ENTRY_LIMIT);

    // Transparent entry always stores black
    always_comb begin
        w_load_data.red   = i_req.red;
        w_load_data.green = i_req.green;
        w_load_data.blue  = i_req.blue;
        if (i_req.entry_index == TRANSPARENT_IDX) begin
            w_load_data = '0;
        end
    end

    // Palette ring: each cell hands its entry to the one below while running
    for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_ring
        npcs_cell u_cell (
            .i_clk        (i_clk),
            .i_load       (w_load && w_load_ok &&
                           (i_req.entry_index == INDEX_W'(g))),
            .i_load_data  (w_load_data),
            .i_shift      (w_shift),
            .i_shift_data (w_cell[(g + 1) % PALETTE_ENTRIES]),
            .o_data       (w_cell[g])
        );
    end

    // Capture the expanded query color
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_query <= expand_color(i_req.color15);
        end
    end

    // Sequencer: state and entry counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                end
            end
            ST_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FLUSH;
                    n_cnt   = '0;
                end
            end
            ST_FLUSH: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_req.ready = 1'b0;
        w_shift     = 1'b0;
        w_out_load  = 1'b0;
        w_ctl.clear = w_query;
        w_ctl.step  = 1'b0;
        w_ctl.index = INDEX_W'(r_cnt);
        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_RUN: begin
                w_shift    = 1'b1;
                w_ctl.step = 1'b1;
            end
            ST_FLUSH: begin
            end
            ST_DONE: begin
                w_out_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
            end
        endcase
    end

    npcs_dist u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_query      (r_query),
        .i_entry      (w_cell[0]),
        .o_best_index (w_best_index),
        .o_best_dist  (w_best_dist)
    );

    // Output register: hold the response until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_index <= w_best_index;
            r_out_dist  <= w_best_dist;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.nearest_index = r_out_index;
    assign o_rsp.min_distance  = r_out_dist;

    // A response appears only at the end of a query
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state == ST_DONE))
        else $error("response raised outside the done state");

    // Ring makes exactly one full turn before the flush
    a_full_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> ($past(r_state == ST_RUN) && $past(r_cnt == CNT_LAST)))
        else $error("flush entered before the ring completed a turn");

    // No word is taken while the ring rotates
    a_no_take_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN || r_state == ST_FLUSH) |-> !i_req.ready)
        else $error("request taken during a search");

endmodule

// ===== src/npcs_cell.sv =====
// One palette cell of the rotating ring: holds one RGB entry.
// Depends on npcs_pkg for the entry type.
module npcs_cell
    import npcs_pkg::*;
(
    input  logic i_clk,
    input  logic i_load,
    input  t_rgb i_load_data,
    input  logic i_shift,
    input  t_rgb i_shift_data,
    output t_rgb o_data
);

    t_rgb r_entry;

    // Take a loaded entry, or the neighbor's entry while the ring rotates
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_load_data;
        end else if (i_shift) begin
            r_entry <= i_shift_data;
        end
    end

    assign o_data = r_entry;

endmodule

// ===== src/npcs_dist.sv =====
// Distance unit: squares channel differences, then keeps the running best.
// Depends on npcs_pkg for types and constants.
module npcs_dist
    import npcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dist_ctl          i_ctl,
    input  t_rgb               i_query,
    input  t_rgb               i_entry,
    output logic [INDEX_W-1:0] o_best_index,
    output logic [DIST_W-1:0]  o_best_dist
);

    t_rgb              w_entry;
    logic [CHAN_W-1:0] w_dr, w_dg, w_db;

    logic              r_s1_valid;
    logic [INDEX_W-1:0] r_s1_index;
    logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;
    logic [DIST_W-1:0] w_sum;

    logic [DIST_W-1:0]  r_best_dist;
    logic [INDEX_W-1:0] r_best_index;

    // Force the transparent entry to black
    always_comb begin
        w_entry = i_entry;
        if (i_ctl.index == TRANSPARENT_IDX) begin
            w_entry = '0;
        end
    end

    // Absolute channel differences
    assign w_dr = (i_query.red >= w_entry.red) ? i_query.red - w_entry.red
                                               : w_entry.red - i_query.red;
    assign w_dg = (i_query.green >= w_entry.green) ? i_query.green - w_entry.green
                                                   : w_entry.green - i_query.green;
    assign w_db = (i_query.blue >= w_entry.blue) ? i_query.blue - w_entry.blue
                                                 : w_entry.blue - i_query.blue;

    // Stage 1: register the three squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_ctl.step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_index <= i_ctl.index;
        r_sq_r     <= w_dr * w_dr;
        r_sq_g     <= w_dg * w_dg;
        r_sq_b     <= w_db * w_db;
    end

    assign w_sum = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    // Stage 2: keep the strictly smaller distance, so the lowest index wins ties
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_best_dist  <= START_DIST;
            r_best_index <= '0;
        end else if (r_s1_valid && (w_sum < r_best_dist)) begin
            r_best_dist  <= w_sum;
            r_best_index <= r_s1_index;
        end
    end

    assign o_best_index = r_best_index;
    assign o_best_dist  = r_best_dist;

endmodule

// ===== bench/npcs_resp_check.sv =====
// Response checker for the nearest palette color search unit.
// Watches the request and response channels, keeps a palette shadow and
// compares every response word with its predicted match. Depends on npcs_pkg, npcs_if.
module npcs_resp_check
    import npcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    npcs_in_if          i_req,
    npcs_out_if         i_rsp,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned REPORT_LIMIT = 10;

    // Predicted answer of one query, with the color kept for reporting
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [INDEX_W-1:0] index;
        logic [DIST_W-1:0]  distance;
    } t_match;

    t_rgb        palette_shadow [PALETTE_ENTRIES_DEF];
    t_match      match_q [$];
    int unsigned fails = 0;

    // Scan the whole shadow palette; strict compare keeps the lowest index on a tie
    function automatic t_match nearest_match(input logic [COLOR_W-1:0] c);
        t_match m;
        t_rgb   ent;
        int     qr, qg, qb, dr, dg, db, d, best;
        qr = int'(c[4:0]) * 8 + 4;
        qg = int'(c[9:5]) * 8 + 4;
        qb = int'(c[14:10]) * 8 + 4;
        best = 32'h7FFF_FFFF;
        m.color = c;
        m.index = '0;
        for (int e = 0; e < PALETTE_ENTRIES_DEF; e++) begin
            ent = (e == int'(TRANSPARENT_IDX)) ? '0 : palette_shadow[e];
            dr = qr - int'(ent.red);
            dg = qg - int'(ent.green);
            db = qb - int'(ent.blue);
            d = dr * dr + dg * dg + db * db;
            if (d < best) begin
                best = d;
                m.index = INDEX_W'(e);
            end
        end
        m.distance = DIST_W'(best);
        return m;
    endfunction

    function automatic void note_failure(input string msg);
        fails++;
        if (fails <= REPORT_LIMIT) begin
            $display("%0t npcs_resp_check mismatch: %s", $realtime, msg);
        end
    endfunction

    always @(posedge i_clk) begin
        t_match want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            // Update the shadow on a load word, queue a prediction on a query word
            if (i_req.valid && i_req.ready) begin
                if (i_req.req_type == REQ_QUERY) begin
                    match_q.push_back(nearest_match(i_req.color15));
                end else if (int'(i_req.entry_index) < PALETTE_ENTRIES_DEF) begin
                    if (i_req.entry_index == TRANSPARENT_IDX) begin
                        palette_shadow[i_req.entry_index] = '0;
                    end else begin
                        palette_shadow[i_req.entry_index] =
                            '{red: i_req.red, green: i_req.green, blue: i_req.blue};
                    end
                end
            end
            // Compare a response word with the oldest prediction
            if (i_rsp.valid && i_rsp.ready) begin
                if (match_q.size() == 0) begin
                    note_failure($sformatf("response index %0d distance %0d with no query open",
                                           i_rsp.nearest_index, i_rsp.min_distance));
                end else begin
                    want = match_q.pop_front();
                    if (i_rsp.nearest_index != want.index) begin
                        note_failure($sformatf("color %h: index exp %0d got %0d",
                                               want.color, want.index, i_rsp.nearest_index));
                    end
                    if (i_rsp.min_distance != want.distance) begin
                        note_failure($sformatf("color %h: distance exp %0d got %0d",
                                               want.color, want.distance, i_rsp.min_distance));
                    end
                end
            end
            o_fail_count <= fails;
            o_pending    <= match_q.size();
        end
    end

endmodule

// ===== bench/nearest_palette_color_search_unit_tb.sv =====
// Testbench top for the nearest palette color search unit.
// Makes clock, reset, request words and response back-pressure, and gives the
// verdict. Depends on npcs_pkg, npcs_if, npcs_resp_check and the unit itself.
module nearest_palette_color_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import npcs_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_WORDS   = 920;
    localparam int RX_HOLD_CYCLES = 2000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int TIMEOUT_CYCLES = 2_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    int unsigned fail_count;
    int unsigned pending_count;
    int          send_idle_pct = 27;
    int          recv_idle_pct = 53;
    int          hold_requests = 0;

    npcs_in_if  req_if ();
    npcs_out_if rsp_if ();

    nearest_palette_color_search_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    npcs_resp_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Give up after a generous fixed time
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("nearest_palette_color_search_unit_tb: FAIL");
        $finish;
    end

    // Drive response ready: random stalls, plus a long hold-off when requested
    initial begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // Offer one word after random idle cycles; return at the falling edge after accept
    task automatic send_word(input logic kind, input logic [INDEX_W-1:0] idx,
                             input t_rgb rgb, input logic [COLOR_W-1:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.entry_index <= idx;
        req_if.red         <= rgb.red;
        req_if.green       <= rgb.green;
        req_if.blue        <= rgb.blue;
        req_if.color15     <= c;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    // Loads carry a random query color and queries random load fields: both are ignored
    task automatic load_entry(input logic [INDEX_W-1:0] idx, input t_rgb rgb);
        send_word(REQ_LOAD, idx, rgb, COLOR_W'($urandom));
    endtask

    task automatic query_color(input logic [COLOR_W-1:0] c);
        send_word(REQ_QUERY, INDEX_W'($urandom), t_rgb'(24'($urandom)), c);
    endtask

    // Load every entry with channels drawn from lo..hi
    task automatic fill_palette(input int lo, input int hi);
        t_rgb rgb;
        for (int e = 0; e < PALETTE_ENTRIES_DEF; e++) begin
            rgb.red   = CHAN_W'($urandom_range(lo, hi));
            rgb.green = CHAN_W'($urandom_range(lo, hi));
            rgb.blue  = CHAN_W'($urandom_range(lo, hi));
            load_entry(INDEX_W'(e), rgb);
        end
    endtask

    // Drop valid and hold until every query has been answered
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
    endtask

    // Palette value that a query color lands on exactly
    function automatic t_rgb exact_rgb(input logic [COLOR_W-1:0] c);
        t_rgb q;
        q.red   = CHAN_W'(int'(c[4:0]) * 8 + 4);
        q.green = CHAN_W'(int'(c[9:5]) * 8 + 4);
        q.blue  = CHAN_W'(int'(c[14:10]) * 8 + 4);
        return q;
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chan();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return CHAN_W'($urandom);
    endfunction

    initial begin
        int                 sent;
        int                 phase;
        int                 a;
        int                 b;
        logic [COLOR_W-1:0] c;
        t_rgb               rgb;

        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_LOAD;
        req_if.entry_index = '0;
        req_if.red         = '0;
        req_if.green       = '0;
        req_if.blue        = '0;
        req_if.color15     = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // All-black palette: every query ties across all entries
        fill_palette(0, 0);
        query_color(15'h7FFF);
        query_color(15'h0000);
        query_color(15'h001F);
        query_color(15'h03E0);
        query_color(15'h7C00);

        // White entry, exact hit, and a load to the transparent entry that stores black
        load_entry(8'd0, '{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
        load_entry(8'd7, exact_rgb(15'h1234));
        load_entry(TRANSPARENT_IDX, '{red: 8'hAB, green: 8'hCD, blue: 8'hEF});
        query_color(15'h1234);
        query_color(15'h7FFF);
        query_color(15'h0000);
        wait_drained();

        // Bright palette: dark queries must land on the transparent entry, then on entry 254 once it holds black
        fill_palette(128, 255);
        query_color(15'h0000);
        query_color(15'h0421);
        load_entry(8'd41, exact_rgb(15'h6B5A));
        load_entry(8'd40, exact_rgb(15'h6B5A));
        query_color(15'h6B5A);
        query_color(15'h7FFF);
        load_entry(8'd254, '{red: 8'h00, green: 8'h00, blue: 8'h00});
        query_color(15'h0000);

        // Random traffic, mostly well-formed load/query sequences
        sent = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            if (phase == 0 && sent >= RANDOM_WORDS / 3) begin
                phase = 1;
                set_idle(53, 27);
                // Stall responses long enough that the unit backs up its input
                hold_requests <= hold_requests + 1;
                repeat (6) begin
                    query_color(COLOR_W'($urandom));
                    sent++;
                end
                wait_drained();
            end else if (phase == 1 && sent >= 2 * RANDOM_WORDS / 3) begin
                phase = 2;
                set_idle(0, 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    rgb.red   = pick_chan();
                    rgb.green = pick_chan();
                    rgb.blue  = pick_chan();
                    load_entry(INDEX_W'($urandom), rgb);
                    sent++;
                end
                4, 5, 6: begin
                    query_color(COLOR_W'($urandom));
                    sent++;
                end
                7: begin
                    c = COLOR_W'($urandom);
                    load_entry(INDEX_W'($urandom), exact_rgb(c));
                    query_color(c);
                    sent += 2;
                end
                8: begin
                    // Same color in two entries: the lower one should win
                    c = COLOR_W'($urandom);
                    a = $urandom_range(0, 253);
                    b = $urandom_range(a + 1, 254);
                    load_entry(INDEX_W'(b), exact_rgb(c));
                    load_entry(INDEX_W'(a), exact_rgb(c));
                    query_color(c);
                    sent += 3;
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: c = 15'h0000;
                        1: c = 15'h7FFF;
                        2: c = 15'h001F;
                        3: c = 15'h03E0;
                        default: c = 15'h7C00;
                    endcase
                    query_color(c);
                    sent++;
                end
            endcase
        end
        req_if.valid <= 1'b0;

        // Wait out open queries, then watch for stray responses
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("nearest_palette_color_search_unit_tb: PASS");
        end else begin
            $display("nearest_palette_color_search_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
